@@ src/sarq_pkg.sv @@
// Shared constants for the shortest-arc rotation quaternion core.
// Holds field widths, fixed-point constants and pipeline latencies; no dependencies.
`timescale 1ns / 1ps

package sarq_pkg;

  localparam int IN_W   = 32;
  localparam int OUT_W  = 32;
  localparam int UNIT_W = 32;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] OPP_TH  = 64'sd1152921504607 - ONE_Q60;

  localparam int SQRT_LAT = 33;
  localparam int DIV_LAT  = 33;
  localparam int PREP_LAT = 5;
  localparam int UNIT_LAT = PREP_LAT + SQRT_LAT + DIV_LAT + 1;
  localparam int POST_LAT = 3;

endpackage

@@ src/sarq_sqrt.sv @@
// Pipelined rounded integer square root, one result bit per stage.
// Depends on sarq_pkg for its latency.
`timescale 1ns / 1ps

module sarq_sqrt
  import sarq_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [32:0] root
);

  localparam int Steps = SQRT_LAT - 1;

  logic [63:0] rem_r   [Steps];
  logic [63:0] acc_r   [Steps];
  logic [63:0] rem_nxt [Steps];
  logic [63:0] acc_nxt [Steps];
  logic [32:0] root_r;
  logic [32:0] root_nxt;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * i);
    logic [63:0] rem_in;
    logic [63:0] acc_in;
    logic [63:0] trial;
    if (i == 0) begin : g_first
      assign rem_in = rad;
      assign acc_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign acc_in = acc_r[i-1];
    end
    assign trial = acc_in + StepBit;
    assign rem_nxt[i] = (rem_in >= trial) ? rem_in - trial : rem_in;
    assign acc_nxt[i] = (rem_in >= trial) ? (acc_in >> 1) + StepBit : acc_in >> 1;
  end

  assign root_nxt = {1'b0, acc_r[Steps-1][31:0]}
                  + 33'(rem_r[Steps-1] > acc_r[Steps-1]);

  always_ff @(posedge clk) begin
    for (int i = 0; i < Steps; i++) begin
      rem_r[i] <= rem_nxt[i];
      acc_r[i] <= acc_nxt[i];
    end
    root_r <= root_nxt;
  end

  assign root = root_r;

endmodule

@@ src/sarq_div.sv @@
// Pipelined restoring divider, 62-bit dividend by 32-bit divisor, rounded and
// saturated at one in Q30. Depends on sarq_pkg for its latency and constants.
`timescale 1ns / 1ps

module sarq_div
  import sarq_pkg::*;
(
  input  logic        clk,
  input  logic [61:0] num,
  input  logic [31:0] den,
  output logic [30:0] quo
);

  localparam int Stages = DIV_LAT - 1;

  logic [31:0] rem_r   [Stages];
  logic [30:0] low_r   [Stages];
  logic [30:0] q_r     [Stages];
  logic [31:0] den_r   [Stages];
  logic        ovf_r   [Stages];
  logic [31:0] rem_nxt [Stages];
  logic [30:0] low_nxt [Stages];
  logic [30:0] q_nxt   [Stages];
  logic [31:0] den_nxt [Stages];
  logic        ovf_nxt [Stages];
  logic [30:0] quo_r;
  logic [30:0] quo_nxt;
  logic        up;
  logic [31:0] qr;

  assign rem_nxt[0] = {1'b0, num[61:31]};
  assign low_nxt[0] = num[30:0];
  assign q_nxt[0]   = '0;
  assign den_nxt[0] = den;
  assign ovf_nxt[0] = ({1'b0, num[61:31]} >= den);

  for (genvar i = 1; i < Stages; i++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_r[i-1], low_r[i-1][30]};
    assign ge = (trial >= {1'b0, den_r[i-1]});
    assign rem_nxt[i] = ge ? 32'(trial - {1'b0, den_r[i-1]}) : trial[31:0];
    assign low_nxt[i] = low_r[i-1] << 1;
    assign q_nxt[i]   = {q_r[i-1][29:0], ge};
    assign den_nxt[i] = den_r[i-1];
    assign ovf_nxt[i] = ovf_r[i-1];
  end

  assign up = ({rem_r[Stages-1], 1'b0} >= {1'b0, den_r[Stages-1]});
  assign qr = {1'b0, q_r[Stages-1]} + 32'(up);
  assign quo_nxt = (ovf_r[Stages-1] || qr > {1'b0, Q30_ONE}) ? Q30_ONE : qr[30:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < Stages; i++) begin
      rem_r[i] <= rem_nxt[i];
      low_r[i] <= low_nxt[i];
      q_r[i]   <= q_nxt[i];
      den_r[i] <= den_nxt[i];
      ovf_r[i] <= ovf_nxt[i];
    end
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

@@ src/sarq_unit.sv @@
// Vector normalizer: power-of-two prescale, sum of squares, rounded length and
// three Q30 divisions. Depends on sarq_pkg, sarq_sqrt and sarq_div.
`timescale 1ns / 1ps

module sarq_unit
  import sarq_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] vec  [3],
  output logic signed [31:0] unit [3]
);

  localparam int MDly = 2 + SQRT_LAT;
  localparam int FDly = MDly + DIV_LAT;

  logic [31:0] mag_r  [3];
  logic [2:0]  neg_r;
  logic [31:0] mag2_r [3];
  logic [2:0]  neg2_r;
  logic [31:0] mx_r;
  logic [31:0] mx_nxt;
  logic [4:0]  sh_nxt;
  logic [31:0] msh_r  [3];
  logic [2:0]  neg3_r;
  logic        zero_r;
  logic [63:0] sq_r   [3];
  logic [63:0] sum_r;
  logic [32:0] len;
  logic [31:0] mdly_r [MDly][3];
  logic [3:0]  fdly_r [FDly];
  logic [30:0] quo    [3];
  logic signed [31:0] unit_r [3];

  function automatic logic [4:0] norm_shift(input logic [31:0] mx);
    logic [31:0] p;
    logic [4:0]  idx;
    p = mx - 32'd1;
    idx = '0;
    for (int i = 0; i < 31; i++) begin
      if (p[i]) idx = 5'(i);
    end
    return (p == '0) ? 5'd31 : 5'd30 - idx;
  endfunction

  always_comb begin
    mx_nxt = mag_r[0];
    if (mag_r[1] > mx_nxt) mx_nxt = mag_r[1];
    if (mag_r[2] > mx_nxt) mx_nxt = mag_r[2];
  end

  assign sh_nxt = norm_shift(mx_r);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_r[i]  <= vec[i][32] ? 32'(-vec[i]) : vec[i][31:0];
      neg_r[i]  <= vec[i][32];
      mag2_r[i] <= mag_r[i];
      msh_r[i]  <= mag2_r[i] << sh_nxt;
      sq_r[i]   <= 64'(msh_r[i]) * 64'(msh_r[i]);
    end
    neg2_r <= neg_r;
    mx_r   <= mx_nxt;
    neg3_r <= neg2_r;
    zero_r <= (mx_r == '0);
    sum_r  <= sq_r[0] + sq_r[1] + sq_r[2];
    mdly_r[0] <= msh_r;
    fdly_r[0] <= {zero_r, neg3_r};
    for (int k = 1; k < MDly; k++) mdly_r[k] <= mdly_r[k-1];
    for (int k = 1; k < FDly; k++) fdly_r[k] <= fdly_r[k-1];
  end

  sarq_sqrt u_len (
    .clk  (clk),
    .rad  (sum_r),
    .root (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    sarq_div u_div (
      .clk (clk),
      .num ({mdly_r[MDly-1][i], 30'd0}),
      .den (len[31:0]),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (fdly_r[FDly-1][3]) begin
        unit_r[i] <= '0;
      end else if (fdly_r[FDly-1][i]) begin
        unit_r[i] <= 32'd0 - {1'b0, quo[i]};
      end else begin
        unit_r[i] <= {1'b0, quo[i]};
      end
    end
  end

  assign unit = unit_r;

endmodule

@@ src/shortest_arc_rotation_quaternion_core.sv @@
// Top level of the shortest-arc rotation quaternion core.
// Depends on sarq_pkg, sarq_unit, sarq_sqrt and sarq_div.
//
//   Channel   Ports                              Handshake
//   input     in_src_x/y/z, in_dst_x/y/z         start while busy is low
//   result    out_quat_w/x/y/z                   out_valid, one cycle
//
// A request is taken every cycle; busy stays low. Each result passes through the
// three parallel normalizer pipelines (rounded square root and Q30 divide) and
// then through the half-angle square root and quotient.
// Reset clears only the valid pipeline; requests in flight are dropped.
// The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps

module shortest_arc_rotation_quaternion_core
  import sarq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_src_x,
  input  logic signed [IN_W-1:0]  in_src_y,
  input  logic signed [IN_W-1:0]  in_src_z,
  input  logic signed [IN_W-1:0]  in_dst_x,
  input  logic signed [IN_W-1:0]  in_dst_y,
  input  logic signed [IN_W-1:0]  in_dst_z,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_quat_w,
  output logic signed [OUT_W-1:0] out_quat_x,
  output logic signed [OUT_W-1:0] out_quat_y,
  output logic signed [OUT_W-1:0] out_quat_z
);

  localparam int CDly  = SQRT_LAT;
  localparam int FDly  = SQRT_LAT + DIV_LAT;
  localparam int WDly  = DIV_LAT;
  localparam int AxDly = POST_LAT + SQRT_LAT + DIV_LAT;
  localparam int Total = UNIT_LAT + AxDly + 1;

  logic signed [32:0] src_v [3];
  logic signed [32:0] dst_v [3];
  logic signed [32:0] ax_v  [3];
  logic               nz;
  logic signed [UNIT_W-1:0] u0 [3];
  logic signed [UNIT_W-1:0] u1 [3];
  logic signed [UNIT_W-1:0] un [3];

  logic signed [63:0] dp_r [3];
  logic signed [63:0] cp_r [6];
  logic signed [63:0] d_r;
  logic signed [63:0] c_r  [3];
  logic               ident_r;
  logic               opp_r;
  logic [63:0]        t_r;
  logic [61:0]        cmag_r [3];
  logic [2:0]         cneg_r;
  logic [32:0]        s;
  logic [33:0]        ws;
  logic [30:0]        w_nxt;
  logic [61:0]        cdly_r [CDly][3];
  logic [4:0]         fdly_r [FDly];
  logic [31:0]        wdly_r [WDly];
  logic signed [UNIT_W-1:0] axdly_r [AxDly][3];
  logic [30:0]        qc [3];
  logic [Total-1:0]   vld_r;
  logic [OUT_W-1:0]   quat_w_r;
  logic [OUT_W-1:0]   quat_r [3];
  logic [OUT_W-1:0]   quat_w_nxt;
  logic [OUT_W-1:0]   quat_nxt [3];

  assign busy = 1'b0;

  assign src_v[0] = 33'(in_src_x);
  assign src_v[1] = 33'(in_src_y);
  assign src_v[2] = 33'(in_src_z);
  assign dst_v[0] = 33'(in_dst_x);
  assign dst_v[1] = 33'(in_dst_y);
  assign dst_v[2] = 33'(in_dst_z);

  assign nz = (in_src_y != '0) || (in_src_z != '0);
  assign ax_v[0] = '0;
  assign ax_v[1] = nz ? -33'(in_src_z) : '0;
  assign ax_v[2] = nz ? 33'(in_src_y) : -33'(in_src_x);

  sarq_unit u_src (.clk(clk), .vec(src_v), .unit(u0));
  sarq_unit u_dst (.clk(clk), .vec(dst_v), .unit(u1));
  sarq_unit u_ax  (.clk(clk), .vec(ax_v),  .unit(un));

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) dp_r[i] <= 64'(u0[i]) * 64'(u1[i]);
    cp_r[0] <= 64'(u0[1]) * 64'(u1[2]);
    cp_r[1] <= 64'(u0[2]) * 64'(u1[1]);
    cp_r[2] <= 64'(u0[2]) * 64'(u1[0]);
    cp_r[3] <= 64'(u0[0]) * 64'(u1[2]);
    cp_r[4] <= 64'(u0[0]) * 64'(u1[1]);
    cp_r[5] <= 64'(u0[1]) * 64'(u1[0]);
    d_r <= dp_r[0] + dp_r[1] + dp_r[2];
    for (int i = 0; i < 3; i++) c_r[i] <= cp_r[2*i] - cp_r[2*i+1];
    ident_r <= (d_r >= ONE_Q60);
    opp_r   <= (d_r < OPP_TH);
    t_r     <= 64'((ONE_Q60 + d_r) <<< 1);
    for (int i = 0; i < 3; i++) begin
      cmag_r[i] <= c_r[i][63] ? 62'(-c_r[i]) : c_r[i][61:0];
      cneg_r[i] <= c_r[i][63];
    end
  end

  sarq_sqrt u_half (
    .clk  (clk),
    .rad  (t_r),
    .root (s)
  );

  assign ws    = (34'(s) + 34'd1) >> 1;
  assign w_nxt = (ws > 34'(Q30_ONE)) ? Q30_ONE : ws[30:0];

  for (genvar i = 0; i < 3; i++) begin : g_div
    sarq_div u_div (
      .clk (clk),
      .num (cdly_r[CDly-1][i]),
      .den (s[31:0]),
      .quo (qc[i])
    );
  end

  always_ff @(posedge clk) begin
    cdly_r[0]  <= cmag_r;
    fdly_r[0]  <= {ident_r, opp_r, cneg_r};
    wdly_r[0]  <= {s == '0, w_nxt};
    axdly_r[0] <= un;
    for (int k = 1; k < CDly; k++)  cdly_r[k]  <= cdly_r[k-1];
    for (int k = 1; k < FDly; k++)  fdly_r[k]  <= fdly_r[k-1];
    for (int k = 1; k < WDly; k++)  wdly_r[k]  <= wdly_r[k-1];
    for (int k = 1; k < AxDly; k++) axdly_r[k] <= axdly_r[k-1];
  end

  always_comb begin
    quat_w_nxt = {1'b0, Q30_ONE};
    for (int i = 0; i < 3; i++) quat_nxt[i] = '0;
    if (fdly_r[FDly-1][4]) begin
      quat_w_nxt = {1'b0, Q30_ONE};
    end else if (fdly_r[FDly-1][3]) begin
      quat_w_nxt = '0;
      for (int i = 0; i < 3; i++) quat_nxt[i] = axdly_r[AxDly-1][i];
    end else if (!wdly_r[WDly-1][31]) begin
      quat_w_nxt = {1'b0, wdly_r[WDly-1][30:0]};
      for (int i = 0; i < 3; i++) begin
        quat_nxt[i] = fdly_r[FDly-1][i] ? 32'd0 - {1'b0, qc[i]} : {1'b0, qc[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    quat_w_r <= quat_w_nxt;
    for (int i = 0; i < 3; i++) quat_r[i] <= quat_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Total-2:0], start & ~busy};
    end
  end

  assign out_valid  = vld_r[Total-1];
  assign out_quat_w = quat_w_r;
  assign out_quat_x = quat_r[0];
  assign out_quat_y = quat_r[1];
  assign out_quat_z = quat_r[2];

endmodule
